>>> design/vrd_pkg.sv
// shared types, constants and the arctangent table for the vector rotation unit
package vrd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int COEF_SHIFT   = 30;
    localparam int ZW           = 33;
    localparam int CW           = 33;
    localparam int QAW          = 3;
    localparam int QDEPTH       = 1 << QAW;

    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

    localparam logic [16:0] UNITS_QUARTER    = 17'd23040;
    localparam logic [16:0] UNITS_HALF       = 17'd46080;
    localparam logic [16:0] UNITS_THREE_QTR  = 17'd69120;
    localparam logic [16:0] UNITS_TURN       = 17'd92160;

    // z = mag * Z_WHOLE + floor((mag * Z_REM + Z_BIAS) / 45)
    localparam logic [15:0] Z_WHOLE    = 16'd46603;
    localparam logic [4:0]  Z_REM      = 5'd17;
    localparam logic [4:0]  Z_BIAS     = 5'd22;
    localparam logic [20:0] Z_RECIP    = 21'd1491309;
    localparam int          Z_RECIP_SH = 26;

    typedef struct packed {
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_item;

    typedef struct packed {
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 flip;
    } t_rot;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85005268;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/vector_rotate_degrees_unit.sv
// top level of the vector rotation unit: front, queue, cordic pipeline and scaling
//
//  channel | valid        | ready        | beat fields
//  --------+--------------+--------------+--------------------------------
//  in      | i_in_valid   | o_in_ready   | i_x_in, i_y_in, i_angle_deg
//  out     | o_out_valid  | i_out_ready  | o_x_out, o_y_out
//
// one beat in and one beat out per cycle, sustained while output beats are taken
// and the queue has room; the pipeline depth is set by the unrolled cordic stages.
// the front never stalls; it takes beats while its stages and the 8-entry queue
// have room, so input keeps flowing while an output beat waits.
// the cordic and scaling stages hold together when the output beat is not taken.
// synchronous active-low reset clears valid flags, queue pointers and queue count only.
module vector_rotate_degrees_unit
    import vrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_in,
    input  logic signed [31:0] i_y_in,
    input  logic signed [17:0] i_angle_deg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_x_out,
    output logic signed [31:0] o_y_out
);

    logic          w_push, w_pop, w_empty, w_adv, w_rot_valid;
    logic [QAW:0]  w_count;
    t_item         w_front_item, w_head;
    t_rot          w_rot;

    assign w_pop = w_adv & !w_empty;

    vrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_x       (i_x_in),
        .i_y       (i_y_in),
        .i_angle   (i_angle_deg),
        .i_q_count (w_count),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    vrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    vrd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pop),
        .i_item  (w_head),
        .o_valid (w_rot_valid),
        .o_rot   (w_rot)
    );

    vrd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_valid),
        .i_rot   (w_rot),
        .i_ready (i_out_ready),
        .o_adv   (w_adv),
        .o_valid (o_out_valid),
        .o_x     (o_x_out),
        .o_y     (o_y_out)
    );

endmodule

>>> design/vrd_front.sv
// input side: angle reduction, quadrant fold and conversion to a binary angle
module vrd_front
    import vrd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    input  logic signed [17:0]  i_angle,
    input  logic [QAW:0]        i_q_count,
    output logic                o_push,
    output t_item               o_item
);

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [31:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic [16:0]        r_r0;
    logic [14:0]        r_mag;
    logic               r_neg2, r_flip2, r_neg3, r_flip3;
    logic [30:0]        r_p1;
    logic [13:0]        r_q;
    t_item              r_item;

    logic signed [19:0] w_a;
    logic signed [19:0] n_r0;
    logic [16:0]        n_mag;
    logic               n_neg, n_flip;
    logic [19:0]        w_v;
    logic [39:0]        w_prod;
    logic [30:0]        w_zmag;
    logic [QAW+1:0]     w_used;
    logic               w_accept;

    assign w_used = (QAW+2)'(r_v1) + (QAW+2)'(r_v2) + (QAW+2)'(r_v3) + (QAW+2)'(r_v4)
                  + (QAW+2)'(i_q_count);
    assign o_ready  = w_used < (QAW+2)'(QDEPTH);
    assign w_accept = i_valid & o_ready;

    // one turn reduction into [0, turn)
    assign w_a = {{2{i_angle[17]}}, i_angle};
    always_comb begin
        if (w_a >= 20'sd92160) begin
            n_r0 = w_a - 20'sd92160;
        end else if (w_a >= 20'sd0) begin
            n_r0 = w_a;
        end else if (w_a >= -20'sd92160) begin
            n_r0 = w_a + 20'sd92160;
        end else begin
            n_r0 = w_a + 20'sd184320;
        end
    end

    // fold into +-90 degrees, magnitude and sign
    always_comb begin
        if (r_r0 <= UNITS_QUARTER) begin
            n_mag  = r_r0;
            n_neg  = 1'b0;
            n_flip = 1'b0;
        end else if (r_r0 <= UNITS_HALF) begin
            n_mag  = UNITS_HALF - r_r0;
            n_neg  = 1'b1;
            n_flip = 1'b1;
        end else if (r_r0 < UNITS_THREE_QTR) begin
            n_mag  = r_r0 - UNITS_HALF;
            n_neg  = 1'b0;
            n_flip = 1'b1;
        end else begin
            n_mag  = UNITS_TURN - r_r0;
            n_neg  = 1'b1;
            n_flip = 1'b0;
        end
    end

    assign w_v    = 20'(r_mag) * 20'(Z_REM) + 20'(Z_BIAS);
    assign w_prod = 40'(w_v) * 40'(Z_RECIP);
    assign w_zmag = r_p1 + 31'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= i_x;
        r_y1    <= i_y;
        r_r0    <= n_r0[16:0];
        r_x2    <= r_x1;
        r_y2    <= r_y1;
        r_mag   <= n_mag[14:0];
        r_neg2  <= n_neg;
        r_flip2 <= n_flip;
        r_x3    <= r_x2;
        r_y3    <= r_y2;
        r_p1    <= 31'(r_mag) * 31'(Z_WHOLE);
        r_q     <= w_prod[Z_RECIP_SH+13:Z_RECIP_SH];
        r_neg3  <= r_neg2;
        r_flip3 <= r_flip2;
        r_item.x    <= r_x3;
        r_item.y    <= r_y3;
        r_item.z    <= r_neg3 ? (ZW'(0) - ZW'(w_zmag)) : ZW'(w_zmag);
        r_item.flip <= r_flip3;
    end

    assign o_push = r_v4;
    assign o_item = r_item;

endmodule

>>> design/vrd_queue.sv
// small first-in first-out queue between the front and the rotation pipeline
module vrd_queue
    import vrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output logic          o_empty,
    output logic [QAW:0]  o_count
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             w_pop;

    assign w_pop   = i_pop & (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(w_pop);
        end
    end

endmodule

>>> design/vrd_cordic.sv
// unrolled rotation-mode cordic pipeline producing cos and sin of the angle
module vrd_cordic
    import vrd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_item  i_item,
    output logic   o_valid,
    output t_rot   o_rot
);

    typedef struct packed {
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_cst;

    t_cst r_st  [CORDIC_STEPS+1];
    logic r_vld [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0].x    <= i_item.x;
            r_st[0].y    <= i_item.y;
            r_st[0].cx   <= GAIN_Q30;
            r_st[0].cy   <= '0;
            r_st[0].z    <= i_item.z;
            r_st[0].flip <= i_item.flip;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_cst                 n_st;
        logic signed [CW-1:0] w_dx, w_dy;
        logic signed [ZW-1:0] w_at;

        assign w_dx = $signed(r_st[k].cy) >>> k;
        assign w_dy = $signed(r_st[k].cx) >>> k;
        assign w_at = $signed(ZW'(atan_turn(k)));

        always_comb begin
            n_st = r_st[k];
            if (!r_st[k].z[ZW-1]) begin
                n_st.cx = r_st[k].cx - w_dx;
                n_st.cy = r_st[k].cy + w_dy;
                n_st.z  = r_st[k].z - w_at;
            end else begin
                n_st.cx = r_st[k].cx + w_dx;
                n_st.cy = r_st[k].cy - w_dy;
                n_st.z  = r_st[k].z + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    assign o_valid     = r_vld[CORDIC_STEPS];
    assign o_rot.x     = r_st[CORDIC_STEPS].x;
    assign o_rot.y     = r_st[CORDIC_STEPS].y;
    assign o_rot.cx    = r_st[CORDIC_STEPS].cx;
    assign o_rot.cy    = r_st[CORDIC_STEPS].cy;
    assign o_rot.flip  = r_st[CORDIC_STEPS].flip;

endmodule

>>> design/vrd_scale.sv
// coefficient sign, products, rounding, saturation and the output register
module vrd_scale
    import vrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_rot               i_rot,
    input  logic               i_ready,
    output logic               o_adv,
    output logic               o_valid,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (COEF_SHIFT - 1);
    localparam logic signed [63:0] SAT_MAX    = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN    = -64'sd2147483648;

    logic               r_v1, r_v2, r_v3, r_vo;
    logic signed [31:0] r_x1, r_y1, r_c, r_s;
    logic signed [63:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [63:0] r_sx, r_sy;
    logic signed [31:0] r_xo, r_yo;

    logic signed [63:0] w_tx, w_ty;
    logic signed [31:0] n_xo, n_yo;

    assign o_adv = !r_vo | i_ready;

    assign w_tx = r_sx >>> COEF_SHIFT;
    assign w_ty = r_sy >>> COEF_SHIFT;

    always_comb begin
        if (w_tx > SAT_MAX) begin
            n_xo = SAT_MAX[31:0];
        end else if (w_tx < SAT_MIN) begin
            n_xo = SAT_MIN[31:0];
        end else begin
            n_xo = w_tx[31:0];
        end
        if (w_ty > SAT_MAX) begin
            n_yo = SAT_MAX[31:0];
        end else if (w_ty < SAT_MIN) begin
            n_yo = SAT_MIN[31:0];
        end else begin
            n_yo = w_ty[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (o_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_x1  <= i_rot.x;
            r_y1  <= i_rot.y;
            r_c   <= 32'(i_rot.flip ? -i_rot.cx : i_rot.cx);
            r_s   <= 32'(i_rot.flip ? -i_rot.cy : i_rot.cy);
            r_pxc <= 64'(r_x1) * 64'(r_c);
            r_pys <= 64'(r_y1) * 64'(r_s);
            r_pxs <= 64'(r_x1) * 64'(r_s);
            r_pyc <= 64'(r_y1) * 64'(r_c);
            r_sx  <= r_pxc - r_pys + ROUND_HALF;
            r_sy  <= r_pxs + r_pyc + ROUND_HALF;
            r_xo  <= n_xo;
            r_yo  <= n_yo;
        end
    end

    assign o_valid = r_vo;
    assign o_x     = r_xo;
    assign o_y     = r_yo;

endmodule

>>> tb/sv/tb_vector_rotate_degrees_unit.sv
// testbench for the vector rotation unit: random and directed beats checked against a predictor
`timescale 1ns / 1ps

module tb_vector_rotate_degrees_unit
    import vrd_pkg::*;
();

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [17:0] ang;
    } t_vec_beat;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_rot_result;

    localparam longint TURN_UNITS    = 92160;
    localparam longint HALF_UNITS    = 46080;
    localparam longint QUARTER_UNITS = 23040;
    localparam longint START_GAIN    = 652032874;
    localparam int     RANDOM_BEATS  = 950;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     DRAIN_CYCLES  = 80;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE   = 32'sh00010000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_x_in = '0;
    logic signed [31:0] i_y_in = '0;
    logic signed [17:0] i_angle_deg = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;

    longint atan_turns [0:31] = '{
        536870912, 316933406, 167458907, 85005268, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0
    };

    t_vec_beat   pending_beats[$];
    t_rot_result expected_rot[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int saturated_seen = 0;
    int wrapped_angles = 0;
    int cycle_count = 0;

    vector_rotate_degrees_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_angle_deg (i_angle_deg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_rot_result rotate_vector(input t_vec_beat b);
        longint      turn_pos;
        longint      num;
        longint      z;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        longint      px;
        longint      py;
        bit          flip;
        t_rot_result r;
        flip = 1'b0;
        turn_pos = longint'(b.ang) % TURN_UNITS;
        if (turn_pos < 0) begin
            turn_pos += TURN_UNITS;
        end
        if (turn_pos > HALF_UNITS) begin
            turn_pos -= TURN_UNITS;
        end
        if (turn_pos > QUARTER_UNITS) begin
            turn_pos -= HALF_UNITS;
            flip = 1'b1;
        end else if (turn_pos < -QUARTER_UNITS) begin
            turn_pos += HALF_UNITS;
            flip = 1'b1;
        end
        // binary angle, one turn is 2^32, rounded half away from zero
        num = turn_pos * 2097152;
        if (num >= 0) begin
            z = (num + 22) / 45;
        end else begin
            z = -((-num + 22) / 45);
        end
        cx = START_GAIN;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= atan_turns[i];
            end else begin
                cx += dx;
                cy -= dy;
                z += atan_turns[i];
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        px = longint'(b.x) * c - longint'(b.y) * s;
        py = longint'(b.x) * s + longint'(b.y) * c;
        r.x = clamp_q16((px + (64'sd1 <<< 29)) >>> 30);
        r.y = clamp_q16((py + (64'sd1 <<< 29)) >>> 30);
        return r;
    endfunction

    task automatic queue_beat(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [17:0] ang);
        t_vec_beat b;
        b.x = x;
        b.y = y;
        b.ang = ang;
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [31:0] random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return $urandom();
        end else if (pick < 80) begin
            return $signed($urandom_range(32'h200000)) - 32'sh100000;
        end else if (pick < 90) begin
            return $urandom_range(1) ? Q_MAX - $urandom_range(1000)
                                      : Q_MIN + $urandom_range(1000);
        end
        return $signed($urandom_range(2)) - 1;
    endfunction

    function automatic logic signed [17:0] random_angle();
        int     pick;
        longint a;
        pick = $urandom_range(99);
        if (pick < 70) begin
            a = longint'($urandom_range(32'(2 * TURN_UNITS))) - TURN_UNITS;
        end else if (pick < 85) begin
            a = longint'($signed($urandom() & 32'h3ffff) <<< 14) >>> 14;
        end else begin
            a = (longint'($urandom_range(8)) - 4) * QUARTER_UNITS
                + longint'($urandom_range(2)) - 1;
        end
        return a[17:0];
    endfunction

    task automatic wait_for_drain();
        while (pending_beats.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_vec_beat   b;
        t_rot_result exp_r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                b.x = i_x_in;
                b.y = i_y_in;
                b.ang = i_angle_deg;
                exp_r = rotate_vector(b);
                expected_rot.push_back(exp_r);
                beats_sent++;
                if (i_angle_deg > 18'sd92160 || i_angle_deg < -18'sd92160) begin
                    wrapped_angles++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    b = pending_beats.pop_front();
                    i_x_in <= b.x;
                    i_y_in <= b.y;
                    i_angle_deg <= b.ang;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rot_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_checked++;
                if (o_x_out == Q_MAX || o_x_out == Q_MIN || o_y_out == Q_MAX
                    || o_y_out == Q_MIN) begin
                    saturated_seen++;
                end
                if (expected_rot.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected output beat x=%0d y=%0d",
                             $time, o_x_out, o_y_out);
                end else begin
                    exp_r = expected_rot.pop_front();
                    if (o_x_out !== exp_r.x || o_y_out !== exp_r.y) begin
                        error_count++;
                        $display("%0t: mismatch expected x=%0d y=%0d, got x=%0d y=%0d",
                                 $time, exp_r.x, exp_r.y, o_x_out, o_y_out);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_rot.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int phase_beats;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, quarter turns, folds, wraps, extremes, saturation
        queue_beat(ONE, 32'sd0, 18'sd0);
        queue_beat(ONE, 32'sd0, 18'sd23040);
        queue_beat(ONE, 32'sd0, -18'sd23040);
        queue_beat(ONE, 32'sd0, 18'sd23039);
        queue_beat(ONE, 32'sd0, 18'sd23041);
        queue_beat(ONE, 32'sd0, -18'sd23041);
        queue_beat(ONE, ONE >>> 1, 18'sd46080);
        queue_beat(ONE, 32'sd0, -18'sd46080);
        queue_beat(ONE, ONE <<< 1, 18'sd69120);
        queue_beat(ONE * 3, -ONE, -18'sd69120);
        queue_beat(Q_MAX, Q_MIN, 18'sd92160);
        queue_beat(Q_MIN, Q_MAX, -18'sd92160);
        queue_beat(ONE, ONE, 18'sd131071);
        queue_beat(-ONE, ONE * 2, -18'sd131072);
        queue_beat(Q_MAX, Q_MAX, 18'sd11520);
        queue_beat(Q_MIN, Q_MIN, 18'sd11520);
        queue_beat(Q_MIN, 32'sd0, 18'sd46080);
        queue_beat(32'sd0, 32'sd0, 18'sd12345);
        queue_beat(-32'sd1, -32'sd1, 18'sd1);
        queue_beat(32'sd1, 32'sd1, -18'sd1);
        queue_beat(Q_MAX, 32'sd0, 18'sd46079);
        queue_beat(32'sd0, Q_MAX, -18'sd46079);
        queue_beat(32'sd12345678, -32'sd87654321, 18'sd7680);
        wait_for_drain();

        // random phases: no idling, sender idle, receiver stall, both
        phase_beats = RANDOM_BEATS / 4;
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 8 : 0;
            recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 8 : 0;
            for (int n = 0; n < phase_beats + ((phase == 3) ? RANDOM_BEATS % 4 : 0); n++) begin
                queue_beat(random_coord(), random_coord(), random_angle());
            end
            wait_for_drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (expected_rot.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d beats sent, %0d results checked, %0d saturated results",
                 beats_sent, beats_checked, saturated_seen);
        $display("%0d angles beyond one turn, idle phases on both channels exercised",
                 wrapped_angles);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/vrd_pkg.sv
design/vrd_front.sv
design/vrd_queue.sv
design/vrd_cordic.sv
design/vrd_scale.sv
design/vector_rotate_degrees_unit.sv
tb/sv/tb_vector_rotate_degrees_unit.sv
